// ===== hw/rtl/rmts_pkg.sv =====
// Shared types and constants for the rate-monotonic tick scheduler.
// No dependencies; imported by every module of the block.
package rmts_pkg;

  // Configuration slots for tasks; registers beyond NUM_TASKS are stored but unused.
  localparam int SLOTS  = 4;
  localparam int SLOT_W = 2;

  // Configuration register index map.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_BASE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_BASE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT       = 4'd8;

  // Selection codes: 0..3 name a task.
  localparam logic [2:0] CHOICE_IDLE = 3'd4;
  localparam logic [2:0] CHOICE_NONE = 3'd7;

  typedef logic [SLOTS-1:0][15:0] rmts_cfg_arr_t;

  typedef struct packed {
    logic [1:0]  running_task;
    logic        cpu_idle;
    logic        choice_changed;
    logic [15:0] tick_time;
  } rmts_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } rmts_state_t;

endpackage

// ===== hw/rtl/rmts_state_ram.sv =====
// Per-task state memory: remaining work and release countdown for each task.
// Synchronous write, registered read; valid bits make cleared entries read as zero.
module rmts_state_ram #(
  parameter int NUM_TASKS  = 4,
  parameter int COUNT_BITS = 16,
  parameter int IDX_W      = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [COUNT_BITS-1:0] rd_work,
  output logic [COUNT_BITS-1:0] rd_cd,
  input  logic                  we,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [COUNT_BITS-1:0] wr_work,
  input  logic [COUNT_BITS-1:0] wr_cd
);
  import rmts_pkg::*;

  logic [2*COUNT_BITS-1:0] mem [NUM_TASKS];
  logic [NUM_TASKS-1:0]    valid_r;
  logic [2*COUNT_BITS-1:0] rd_data_r;
  logic                    rd_valid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= {wr_work, wr_cd};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // An entry counts as zero until it has been written since the last clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (clear) begin
        valid_r <= '0;
      end else if (we) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_work = rd_valid_r ? rd_data_r[2*COUNT_BITS-1:COUNT_BITS] : '0;
  assign rd_cd   = rd_valid_r ? rd_data_r[COUNT_BITS-1:0] : '0;

endmodule

// ===== hw/rtl/rmts_sched_core.sv =====
// Scheduler sequencer: walks the task state memory once per tick, applies releases,
// picks the rate-monotonic winner and charges it one tick. Uses rmts_pkg and rmts_state_ram.
module rmts_sched_core #(
  parameter int NUM_TASKS  = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tick_valid,
  input  logic                  tick_restart,
  output logic                  tick_ready,
  input  rmts_pkg::rmts_cfg_arr_t burst,
  input  rmts_pkg::rmts_cfg_arr_t period,
  output logic                  res_valid,
  input  logic                  res_ready,
  output rmts_pkg::rmts_result_t res
);
  import rmts_pkg::*;

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

  rmts_state_t           state_r, state_nxt;
  logic [IDX_W-1:0]      idx_r;
  logic                  found_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [15:0]           best_period_r;
  logic [COUNT_BITS-1:0] best_work_r;
  logic [COUNT_BITS-1:0] best_cd_r;
  logic [2:0]            prev_choice_r;
  logic [15:0]           time_r;

  logic                  accept;
  logic                  rd_en;
  logic                  we;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_work;
  logic [COUNT_BITS-1:0] wr_cd;
  logic [COUNT_BITS-1:0] rd_work;
  logic [COUNT_BITS-1:0] rd_cd;
  logic [15:0]           cur_burst;
  logic [15:0]           cur_period;
  logic [COUNT_BITS-1:0] new_work;
  logic [COUNT_BITS-1:0] new_cd;
  logic                  take;
  logic [2:0]            choice;

  function automatic logic [COUNT_BITS-1:0] clamp_cnt(input logic [15:0] v);
    logic [31:0] ext;
    ext = {16'b0, v};
    if (ext > CNT_MAX) begin
      return CNT_MAX[COUNT_BITS-1:0];
    end
    return ext[COUNT_BITS-1:0];
  endfunction

  rmts_state_ram #(
    .NUM_TASKS (NUM_TASKS),
    .COUNT_BITS(COUNT_BITS),
    .IDX_W     (IDX_W)
  ) u_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (accept && tick_restart),
    .rd_en  (rd_en),
    .rd_addr(idx_r),
    .rd_work(rd_work),
    .rd_cd  (rd_cd),
    .we     (we),
    .wr_addr(wr_addr),
    .wr_work(wr_work),
    .wr_cd  (wr_cd)
  );

  assign accept     = tick_valid && tick_ready;
  assign cur_burst  = burst[SLOT_W'(idx_r)];
  assign cur_period = period[SLOT_W'(idx_r)];

  // Release update and candidate compare for the entry just read.
  always_comb begin
    new_work = rd_work;
    new_cd   = rd_cd;
    if (cur_period == 16'd0) begin
      new_work = '0;
      new_cd   = '0;
    end else if (rd_cd == '0) begin
      new_work = clamp_cnt(cur_burst);
      new_cd   = clamp_cnt(cur_period - 16'd1);
    end else begin
      new_cd = rd_cd - COUNT_BITS'(1);
    end
    take = (cur_period != 16'd0) && (new_work != '0) &&
           (!found_r || (cur_period < best_period_r));
  end

  always_comb begin
    state_nxt  = state_r;
    tick_ready = 1'b0;
    rd_en      = 1'b0;
    we         = 1'b0;
    wr_addr    = idx_r;
    wr_work    = new_work;
    wr_cd      = new_cd;
    res_valid  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        tick_ready = 1'b1;
        if (tick_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        we = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_FINISH: begin
        // The winner is charged one tick; rewriting while stalled is harmless.
        res_valid = 1'b1;
        we        = found_r;
        wr_addr   = best_idx_r;
        wr_work   = best_work_r - COUNT_BITS'(1);
        wr_cd     = best_cd_r;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      idx_r         <= '0;
      found_r       <= 1'b0;
      prev_choice_r <= CHOICE_NONE;
      time_r        <= 16'd0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        if (tick_restart) begin
          prev_choice_r <= CHOICE_NONE;
          time_r        <= 16'd0;
        end
      end
      if (state_r == ST_EVAL) begin
        if (take) begin
          found_r <= 1'b1;
        end
        if (idx_r != LAST_IDX) begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      if (state_r == ST_FINISH && res_ready) begin
        prev_choice_r <= choice;
        time_r        <= time_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EVAL && take) begin
      best_idx_r    <= idx_r;
      best_period_r <= cur_period;
      best_work_r   <= new_work;
      best_cd_r     <= new_cd;
    end
  end

  assign choice             = found_r ? 3'(best_idx_r) : CHOICE_IDLE;
  assign res.running_task   = found_r ? 2'(best_idx_r) : 2'b00;
  assign res.cpu_idle       = !found_r;
  assign res.choice_changed = (choice != prev_choice_r);
  assign res.tick_time      = time_r;

`ifndef ASSERT_OFF
  a_task_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.cpu_idle |-> 32'(res.running_task) < NUM_TASKS)
    else $error("running task index beyond the task count");

  a_idle_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.cpu_idle |-> res.running_task == 2'b00)
    else $error("idle result carries a nonzero task index");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && tick_restart |=> time_r == 16'd0 && prev_choice_r == CHOICE_NONE)
    else $error("restart did not clear time and previous choice");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");
`endif

endmodule

// ===== hw/rtl/rate_monotonic_tick_scheduler.sv =====
// Rate-monotonic tick scheduler, top level. Depends on rmts_pkg and rmts_sched_core.
// Each tick is taken in the idle state, then every task is read and written back in turn
// on the state memory, and the result is handed to the output register. A new tick is
// taken only after the previous one has handed off its result; that result waits in the
// output register so the next tick can start. Reset (synchronous, active low) zeroes
// configuration, task state, time and marks the previous choice as none.
module rate_monotonic_tick_scheduler #(
  parameter int NUM_TASKS  = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_running_task,
  output logic                           out_cpu_idle,
  output logic                           out_choice_changed,
  output logic [15:0]                    out_tick_time,
  input  logic                           cfg_we,
  input  logic [rmts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_wdata
);
  import rmts_pkg::*;

  // Configuration registers: bursts and periods for every slot. Slots at or
  // above NUM_TASKS are kept but never walked by the core.
  rmts_cfg_arr_t burst_r;
  rmts_cfg_arr_t period_r;

  // Output register that parts the core from the result channel.
  logic         out_valid_r;
  rmts_result_t out_res_r;

  logic         core_res_valid;
  logic         core_res_ready;
  rmts_result_t core_res;

  // Writes to indexes past the last period register are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r  <= '0;
      period_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index < REG_PERIOD_BASE) begin
        burst_r[SLOT_W'(cfg_index - REG_BURST_BASE)] <= cfg_wdata;
      end else if (cfg_index < REG_COUNT) begin
        period_r[SLOT_W'(cfg_index - REG_PERIOD_BASE)] <= cfg_wdata;
      end
    end
  end

  rmts_sched_core #(
    .NUM_TASKS (NUM_TASKS),
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_valid  (in_valid),
    .tick_restart(in_restart),
    .tick_ready  (in_ready),
    .burst       (burst_r),
    .period      (period_r),
    .res_valid   (core_res_valid),
    .res_ready   (core_res_ready),
    .res         (core_res)
  );

  // The core may hand over a new result whenever the register is empty or is
  // being emptied by a transfer in this same cycle.
  assign core_res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_res_ready) begin
      out_valid_r <= core_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_valid && core_res_ready) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_running_task   = out_res_r.running_task;
  assign out_cpu_idle       = out_res_r.cpu_idle;
  assign out_choice_changed = out_res_r.choice_changed;
  assign out_tick_time      = out_res_r.tick_time;

endmodule

// ===== tb/tb_rate_monotonic_tick_scheduler.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rate_monotonic_tick_scheduler: ticks go through a valid/ready
// driver, results are checked against a cycle-free schedule predictor. Needs rmts_pkg and the RTL.
module tb_rate_monotonic_tick_scheduler;
  import rmts_pkg::*;

  // Per-tick allowance used to size the drain at the end of the run.
  localparam int LATENCY      = 10;
  // Watchdog bound on the length of the whole run.
  localparam int CYCLE_LIMIT  = 200_000;
  // Length of the run with no idling on either side.
  localparam int STEADY_TICKS = 120;
  localparam int IDLE_PCT     = 27;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_running_task;
  logic        out_cpu_idle;
  logic        out_choice_changed;
  logic [15:0] out_tick_time;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  rate_monotonic_tick_scheduler u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_running_task   (out_running_task),
    .out_cpu_idle       (out_cpu_idle),
    .out_choice_changed (out_choice_changed),
    .out_tick_time      (out_tick_time),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ticks waiting to be offered (each entry is the restart bit) and the schedule
  // results predicted for ticks that have already been transferred.
  logic         pending_ticks[$];
  rmts_result_t expected_ticks[$];

  int fault_count = 0;
  int cycle_count = 0;
  // When set, neither side inserts idle cycles.
  logic steady_flow = 1'b0;

  // Shadow copy of the configuration registers.
  logic [15:0] burst_cfg  [SLOTS];
  logic [15:0] period_cfg [SLOTS];

  // Shadow copy of the scheduler state.
  logic [15:0] work_left  [SLOTS];
  logic [15:0] countdown  [SLOTS];
  logic [2:0]  last_choice;
  logic [15:0] now_tick;

  task automatic clear_schedule();
    for (int k = 0; k < SLOTS; k++) begin
      work_left[k] = '0;
      countdown[k] = '0;
    end
    last_choice = CHOICE_NONE;
    now_tick    = '0;
  endtask

  // Advances the shadow scheduler by one tick and queues the result it must produce.
  // With 16-bit counters a burst or a period minus one always fits, so no saturation.
  task automatic schedule_tick(input logic restart);
    int           sel;
    logic         found;
    logic [2:0]   choice;
    rmts_result_t res;
    if (restart) clear_schedule();
    // A release reloads work from the burst and discards whatever was left.
    for (int k = 0; k < SLOTS; k++) begin
      if (period_cfg[k] == 16'd0) begin
        work_left[k] = '0;
        countdown[k] = '0;
      end else if (countdown[k] == 16'd0) begin
        work_left[k] = burst_cfg[k];
        countdown[k] = period_cfg[k] - 16'd1;
      end else begin
        countdown[k] = countdown[k] - 16'd1;
      end
    end
    // Shortest period wins; a strict compare leaves ties with the lower index.
    found = 1'b0;
    sel   = 0;
    for (int k = 0; k < SLOTS; k++) begin
      if (period_cfg[k] != 16'd0 && work_left[k] != 16'd0 &&
          (!found || period_cfg[k] < period_cfg[sel])) begin
        sel   = k;
        found = 1'b1;
      end
    end
    choice = found ? 3'(sel) : CHOICE_IDLE;
    res.running_task   = found ? 2'(sel) : 2'd0;
    res.cpu_idle       = !found;
    res.choice_changed = (choice != last_choice);
    res.tick_time      = now_tick;
    expected_ticks.push_back(res);
    if (found) work_left[sel] = work_left[sel] - 16'd1;
    last_choice = choice;
    now_tick    = now_tick + 16'd1;
  endtask

  // Drives one register write; the caller lowers cfg_we after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx < REG_PERIOD_BASE) burst_cfg[idx[1:0]] = val;
    else if (idx < REG_COUNT) period_cfg[idx[1:0]] = val;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] b0, input logic [15:0] b1,
                           input logic [15:0] b2, input logic [15:0] b3,
                           input logic [15:0] p0, input logic [15:0] p1,
                           input logic [15:0] p2, input logic [15:0] p3);
    write_reg(REG_BURST_BASE + 4'd0, b0);
    write_reg(REG_BURST_BASE + 4'd1, b1);
    write_reg(REG_BURST_BASE + 4'd2, b2);
    write_reg(REG_BURST_BASE + 4'd3, b3);
    write_reg(REG_PERIOD_BASE + 4'd0, p0);
    write_reg(REG_PERIOD_BASE + 4'd1, p1);
    write_reg(REG_PERIOD_BASE + 4'd2, p2);
    write_reg(REG_PERIOD_BASE + 4'd3, p3);
    cfg_we <= 1'b0;
  endtask

  // Periods are mostly short so releases overlap; zero and the maximum show up too.
  function automatic logic [15:0] rand_period();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 10));
    endcase
  endfunction

  function automatic logic [15:0] rand_burst();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  // Holds the sender back until every transfer has produced its checked result,
  // so the block is idle and configuration may change.
  task automatic settle();
    while (pending_ticks.size() != 0 || in_valid || expected_ticks.size() != 0)
      @(posedge clk);
  endtask

  // Driver: offers the next tick when the channel is free, with random idle cycles.
  // A tick is predicted at the edge where its transfer completes.
  always @(posedge clk) begin : tick_driver
    logic launch;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) schedule_tick(in_restart);
      if (!in_valid || in_ready) begin
        launch = (pending_ticks.size() != 0) &&
                 (steady_flow || $urandom_range(0, 99) >= IDLE_PCT);
        if (launch) in_restart <= pending_ticks.pop_front();
        in_valid <= launch;
      end
    end
  end

  // Monitor: every result transfer must match the oldest prediction, field by field.
  always @(posedge clk) begin : result_monitor
    rmts_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: result with nothing expected: task %0d idle %0b changed %0b time %0d",
                   $realtime, out_running_task, out_cpu_idle, out_choice_changed,
                   out_tick_time);
      end else begin
        want = expected_ticks.pop_front();
        if (out_running_task !== want.running_task || out_cpu_idle !== want.cpu_idle ||
            out_choice_changed !== want.choice_changed ||
            out_tick_time !== want.tick_time) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: exp/act task %0d/%0d idle %0b/%0b changed %0b/%0b time %0d/%0d",
                     $realtime,
                     want.running_task, out_running_task, want.cpu_idle, out_cpu_idle,
                     want.choice_changed, out_choice_changed, want.tick_time,
                     out_tick_time);
        end
      end
    end
    out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int k;
    int n_items;
    for (k = 0; k < SLOTS; k++) begin
      burst_cfg[k]  = '0;
      period_cfg[k] = '0;
    end
    clear_schedule();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With reset configuration every task is disabled: idle ticks, the first one
    // flagged as a change, and a restart that takes time back to zero.
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b1);
    settle();

    // Tasks 0 and 1 tie on period, task 2 has the shortest period but no work,
    // task 3 is disabled. Writes past the last register must change nothing.
    write_all(16'd2, 16'd1, 16'd0, 16'd3, 16'd4, 16'd4, 16'd3, 16'd0);
    write_reg(REG_COUNT, 16'hFFFF);
    write_reg(REG_COUNT + 4'd7, 16'h1234);
    cfg_we <= 1'b0;
    for (k = 0; k < 14; k++) pending_ticks.push_back(k == 0 || k == 9);
    settle();

    // Extreme values without a restart: periods change while countdowns run, and
    // task 3 leaves the disabled state, so it is released on its next tick.
    write_all(16'd1, 16'hFFFF, 16'd2, 16'hFFFF, 16'd3, 16'hFFFF, 16'd3, 16'hFFFF);
    for (k = 0; k < 8; k++) pending_ticks.push_back(1'b0);
    settle();

    // One long run with no idling on either side. Task 2 takes every other tick,
    // so task 1 cannot finish its burst within its period and its leftover work
    // is dropped at each reload, while task 0 waits behind both of them.
    write_all(16'd3, 16'd20, 16'd1, 16'd5, 16'hFFFF, 16'd30, 16'd2, 16'd0);
    steady_flow = 1'b1;
    pending_ticks.push_back(1'b1);
    repeat (STEADY_TICKS - 1) pending_ticks.push_back(1'b0);
    settle();
    steady_flow = 1'b0;

    // Random phases: mostly full reconfiguration, sometimes only a few registers so
    // that running countdowns meet new periods. Restarts are sprinkled in.
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        write_all(rand_burst(), rand_burst(), rand_burst(), rand_burst(),
                  rand_period(), rand_period(), rand_period(), rand_period());
      end else begin
        repeat ($urandom_range(1, 3)) begin
          k = $urandom_range(0, SLOTS - 1);
          if ($urandom_range(0, 1))
            write_reg(REG_PERIOD_BASE + CFG_IDX_W'(k), rand_period());
          else
            write_reg(REG_BURST_BASE + CFG_IDX_W'(k), rand_burst());
        end
        if ($urandom_range(0, 3) == 0)
          write_reg(REG_COUNT + CFG_IDX_W'($urandom_range(0, 7)),
                    16'($urandom_range(0, 65535)));
        cfg_we <= 1'b0;
      end
      n_items = $urandom_range(50, 80);
      for (k = 0; k < n_items; k++)
        pending_ticks.push_back($urandom_range(0, 99) < 6);
      settle();
    end

    repeat (3 * LATENCY) @(posedge clk);
    if (fault_count == 0 && expected_ticks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
